FILE: src/rms_pkg.sv
// ----------------------------------------------------------------------------
// Rover motion sequencer package
// Shared types, register indexes and command codes of the motion sequencer.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int TIME_BITS = 32;

  // Configuration register indexes.
  localparam logic [2:0] REG_DRIVE_SPEED   = 3'd0;
  localparam logic [2:0] REG_NEAR_LIMIT    = 3'd1;
  localparam logic [2:0] REG_FULL_TURN     = 3'd2;
  localparam logic [2:0] REG_BACKUP        = 3'd3;
  localparam logic [2:0] REG_INSPECT_FWD   = 3'd4;
  localparam logic [2:0] REG_SETTLE_PAUSE  = 3'd5;

  // Command bytes.
  localparam logic [7:0] CMD_NONE    = 8'h30;  // '0'
  localparam logic [7:0] CMD_LF      = 8'h0A;
  localparam logic [7:0] CMD_CR      = 8'h0D;
  localparam logic [7:0] CMD_FWD     = 8'h77;  // 'w'
  localparam logic [7:0] CMD_LEFT    = 8'h61;  // 'a'
  localparam logic [7:0] CMD_STOP    = 8'h73;  // 's'
  localparam logic [7:0] CMD_RIGHT   = 8'h64;  // 'd'
  localparam logic [7:0] CMD_REV     = 8'h78;  // 'x'
  localparam logic [7:0] CMD_TURN_Q  = 8'h71;  // 'q'
  localparam logic [7:0] CMD_TURN_E  = 8'h65;  // 'e'
  localparam logic [7:0] CMD_BACKUP  = 8'h6F;  // 'o'
  localparam logic [7:0] CMD_INSPECT = 8'h63;  // 'c'

  // Inspection phases.
  localparam logic [1:0] PH_FORWARD = 2'd0;
  localparam logic [1:0] PH_PAUSE   = 2'd1;
  localparam logic [1:0] PH_TURN    = 2'd2;
  localparam logic [1:0] PH_REVERSE = 2'd3;

  typedef struct packed {
    logic [7:0]  drive_speed;
    logic [8:0]  near_limit_cm;
    logic [15:0] full_turn_ms;
    logic [15:0] backup_ms;
    logic [15:0] inspect_forward_ms;
    logic [15:0] settle_pause_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [8:0]      left_drive;
    logic signed [8:0]      right_drive;
    logic [7:0]             previous_command;
    logic                   obstacle_flag;
    logic                   turn_active;
    logic [TIME_BITS-1:0]   turn_begin;
    logic [15:0]            turn_length;
    logic                   inspect_active;
    logic [1:0]             inspect_phase;
    logic [TIME_BITS-1:0]   leg_begin;
    logic [TIME_BITS-1:0]   pause_begin;
    logic [TIME_BITS-1:0]   return_length;
    logic                   link_ok;
    logic [TIME_BITS-1:0]   backup_begin;
  } state_t;

  typedef struct packed {
    logic       left_forward;
    logic [7:0] left_pwm;
    logic       right_forward;
    logic [7:0] right_pwm;
    logic       obstacle_seen;
    logic       turning;
    logic       inspecting_now;
    logic       backing_up;
    logic [1:0] inspect_step;
  } result_t;

endpackage

FILE: src/rms_core.sv
// ----------------------------------------------------------------------------
// Rover motion sequencer step logic
// Combinational update of the sequencer state for one control tick.
// ----------------------------------------------------------------------------
module rms_core import rms_pkg::*; (
  input  cfg_t                 cfg,
  input  state_t               st,
  input  logic [TIME_BITS-1:0] now_ms,
  input  logic [8:0]           distance_cm,
  input  logic                 cmd_valid,
  input  logic [7:0]           cmd_byte,
  output state_t               st_next,
  output result_t              res
);

  function automatic logic [TIME_BITS-1:0] elapsed(input logic [TIME_BITS-1:0] now,
                                                   input logic [TIME_BITS-1:0] since);
    return now - since;
  endfunction

  function automatic logic [TIME_BITS-1:0] widen16(input logic [15:0] v);
    return {{(TIME_BITS-16){1'b0}}, v};
  endfunction

  function automatic state_t set_drive(input state_t s, input logic signed [8:0] l,
                                       input logic signed [8:0] r);
    state_t t;
    t = s;
    t.left_drive  = l;
    t.right_drive = r;
    return t;
  endfunction

  function automatic state_t half_turn(input state_t s, input logic [TIME_BITS-1:0] now,
                                       input logic positive, input cfg_t c);
    state_t t;
    logic signed [8:0] sp;
    t  = s;
    sp = $signed({1'b0, c.drive_speed});
    if (!t.turn_active) begin
      t.turn_begin  = now;
      t.turn_length = c.full_turn_ms >> 1;
      if (positive) t = set_drive(t, -sp, sp);
      else t = set_drive(t, sp, -sp);
      t.turn_active = 1'b1;
    end else if (elapsed(now, t.turn_begin) >= widen16(t.turn_length)) begin
      t = set_drive(t, 9'sd0, 9'sd0);
      t.turn_active      = 1'b0;
      t.previous_command = CMD_NONE;
    end
    return t;
  endfunction

  function automatic state_t backup_step(input state_t s, input logic [TIME_BITS-1:0] now,
                                         input cfg_t c);
    state_t t;
    logic signed [8:0] sp;
    t  = s;
    sp = $signed({1'b0, c.drive_speed});
    if (t.link_ok) begin
      t.link_ok      = 1'b0;
      t.backup_begin = now;
      t = set_drive(t, -sp, -sp);
    end else if (elapsed(now, t.backup_begin) >= widen16(c.backup_ms)) begin
      t = set_drive(t, 9'sd0, 9'sd0);
      t.link_ok = 1'b1;
    end
    return t;
  endfunction

  function automatic state_t inspect_advance(input state_t s,
                                             input logic [TIME_BITS-1:0] now,
                                             input cfg_t c);
    state_t t;
    logic signed [8:0] sp;
    t  = s;
    sp = $signed({1'b0, c.drive_speed});
    if (!t.inspect_active) begin
      t.inspect_active = 1'b1;
      t.inspect_phase  = PH_FORWARD;
      t.leg_begin      = now;
    end else begin
      case (t.inspect_phase)
        PH_FORWARD: begin
          if (t.obstacle_flag) begin
            // An obstacle cuts the leg short; the reverse leg retraces it.
            t = set_drive(t, 9'sd0, 9'sd0);
            t.pause_begin   = now;
            t.return_length = elapsed(now, t.leg_begin);
            t.inspect_phase = PH_PAUSE;
          end else if (elapsed(now, t.leg_begin) >= widen16(c.inspect_forward_ms)) begin
            t = set_drive(t, 9'sd0, 9'sd0);
            t.pause_begin   = now;
            t.return_length = widen16(c.inspect_forward_ms);
            t.inspect_phase = PH_PAUSE;
          end else begin
            t = set_drive(t, sp, sp);
          end
        end
        PH_PAUSE: begin
          if (elapsed(now, t.pause_begin) >= widen16(c.settle_pause_ms)) begin
            t = half_turn(t, now, 1'b1, c);
            t.inspect_phase = PH_TURN;
          end
        end
        PH_TURN: begin
          if (!t.turn_active) begin
            t.leg_begin     = now;
            t.inspect_phase = PH_REVERSE;
          end
        end
        default: begin
          if (elapsed(now, t.leg_begin) >= t.return_length) begin
            t = set_drive(t, 9'sd0, 9'sd0);
            t.inspect_active = 1'b0;
            t.inspect_phase  = PH_FORWARD;
          end else begin
            t = set_drive(t, -sp, -sp);
          end
        end
      endcase
    end
    return t;
  endfunction

  state_t            t;
  logic [7:0]        c;
  logic              motion;
  logic signed [8:0] sp;

  always_comb begin
    t  = st;
    sp = $signed({1'b0, cfg.drive_speed});
    c  = CMD_NONE;

    if (distance_cm != 9'd0 && distance_cm < cfg.near_limit_cm) begin
      if (!t.obstacle_flag) begin
        t.obstacle_flag = 1'b1;
        if (t.previous_command == CMD_FWD) t = set_drive(t, 9'sd0, 9'sd0);
      end
    end else begin
      t.obstacle_flag = 1'b0;
    end

    if (!t.link_ok) t = backup_step(t, now_ms, cfg);
    if (t.turn_active) t = half_turn(t, now_ms, 1'b1, cfg);
    if (t.inspect_active) t = inspect_advance(t, now_ms, cfg);

    if (cmd_valid && cmd_byte != CMD_LF && cmd_byte != CMD_CR) begin
      c = cmd_byte;
      t.previous_command = cmd_byte;
    end

    motion = c inside {CMD_FWD, CMD_LEFT, CMD_STOP, CMD_RIGHT, CMD_REV, CMD_TURN_Q,
                       CMD_TURN_E};

    if (c != CMD_NONE) begin
      // Motion commands cancel every timed action first.
      if (motion && (t.turn_active || t.inspect_active || !t.link_ok)) begin
        t.turn_active    = 1'b0;
        t.inspect_active = 1'b0;
        t.link_ok        = 1'b1;
        t.inspect_phase  = PH_FORWARD;
        t = set_drive(t, 9'sd0, 9'sd0);
      end
      unique case (c)
        CMD_FWD: begin
          if (t.obstacle_flag) t = set_drive(t, 9'sd0, 9'sd0);
          else t = set_drive(t, sp, sp);
        end
        CMD_STOP:    t = set_drive(t, 9'sd0, 9'sd0);
        CMD_REV:     t = set_drive(t, -sp, -sp);
        CMD_RIGHT:   t = set_drive(t, sp, -sp);
        CMD_LEFT:    t = set_drive(t, -sp, sp);
        CMD_TURN_Q:  t = half_turn(t, now_ms, 1'b0, cfg);
        CMD_TURN_E:  t = half_turn(t, now_ms, 1'b1, cfg);
        CMD_BACKUP:  t = backup_step(t, now_ms, cfg);
        CMD_INSPECT: t = inspect_advance(t, now_ms, cfg);
        default: ;
      endcase
    end else if (!t.turn_active && !t.inspect_active && t.link_ok) begin
      t = set_drive(t, 9'sd0, 9'sd0);
    end

    st_next = t;

    res.left_forward   = ~t.left_drive[8];
    res.left_pwm       = t.left_drive[8] ? 8'(-t.left_drive) : t.left_drive[7:0];
    res.right_forward  = ~t.right_drive[8];
    res.right_pwm      = t.right_drive[8] ? 8'(-t.right_drive) : t.right_drive[7:0];
    res.obstacle_seen  = t.obstacle_flag;
    res.turning        = t.turn_active;
    res.inspecting_now = t.inspect_active;
    res.backing_up     = ~t.link_ok;
    res.inspect_step   = t.inspect_phase;
  end

endmodule

FILE: src/rover_motion_sequencer.sv
// ----------------------------------------------------------------------------
// Rover motion sequencer
// Obstacle flag, timed half turn, link-lost backup and inspection sequence,
// one control tick per item, two motor outputs per tick.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  now_ms, distance_cm, cmd_valid, cmd_byte
//   out      output     out_valid/out_stall  motor pairs and mode flags
//   config   input      cfg_we               cfg_index, cfg_data
//
// An item is taken into the input register; the step logic then updates the
// state from it and loads the result register, which offers the result. One
// item per cycle is sustained while the output is not stalled. The step logic
// runs only when the result register is empty or being taken, so a stalled
// output stalls the input one item later. Reset restores state and registers;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module rover_motion_sequencer import rms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TIME_BITS-1:0] now_ms,
  input  logic [8:0]           distance_cm,
  input  logic                 cmd_valid,
  input  logic [7:0]           cmd_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 left_forward,
  output logic [7:0]           left_pwm,
  output logic                 right_forward,
  output logic [7:0]           right_pwm,
  output logic                 obstacle_seen,
  output logic                 turning,
  output logic                 inspecting_now,
  output logic                 backing_up,
  output logic [1:0]           inspect_step
);

  cfg_t                 cfg;
  state_t               st;
  state_t               st_next;
  result_t              res_next;
  result_t              res;

  logic                 ir_valid;
  logic [TIME_BITS-1:0] ir_now;
  logic [8:0]           ir_distance;
  logic                 ir_cmd_valid;
  logic [7:0]           ir_cmd_byte;
  logic                 advance;

  assign advance  = ir_valid && (!out_valid || !out_stall);
  assign in_stall = ir_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_speed        <= 8'd150;
      cfg.near_limit_cm      <= 9'd10;
      cfg.full_turn_ms       <= 16'd2000;
      cfg.backup_ms          <= 16'd2000;
      cfg.inspect_forward_ms <= 16'd2000;
      cfg.settle_pause_ms    <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DRIVE_SPEED:  cfg.drive_speed        <= cfg_data[7:0];
        REG_NEAR_LIMIT:   cfg.near_limit_cm      <= cfg_data[8:0];
        REG_FULL_TURN:    cfg.full_turn_ms       <= cfg_data;
        REG_BACKUP:       cfg.backup_ms          <= cfg_data;
        REG_INSPECT_FWD:  cfg.inspect_forward_ms <= cfg_data;
        REG_SETTLE_PAUSE: cfg.settle_pause_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      ir_valid <= 1'b1;
    end else if (advance) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ir_now       <= now_ms;
      ir_distance  <= distance_cm;
      ir_cmd_valid <= cmd_valid;
      ir_cmd_byte  <= cmd_byte;
    end
  end

  rms_core u_core (
    .cfg         (cfg),
    .st          (st),
    .now_ms      (ir_now),
    .distance_cm (ir_distance),
    .cmd_valid   (ir_cmd_valid),
    .cmd_byte    (ir_cmd_byte),
    .st_next     (st_next),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.left_drive       <= 9'sd0;
      st.right_drive      <= 9'sd0;
      st.previous_command <= CMD_NONE;
      st.obstacle_flag    <= 1'b0;
      st.turn_active      <= 1'b0;
      st.turn_begin       <= '0;
      st.turn_length      <= 16'd0;
      st.inspect_active   <= 1'b0;
      st.inspect_phase    <= PH_FORWARD;
      st.leg_begin        <= '0;
      st.pause_begin      <= '0;
      st.return_length    <= TIME_BITS'(2000);
      st.link_ok          <= 1'b1;
      st.backup_begin     <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign left_forward   = res.left_forward;
  assign left_pwm       = res.left_pwm;
  assign right_forward  = res.right_forward;
  assign right_pwm      = res.right_pwm;
  assign obstacle_seen  = res.obstacle_seen;
  assign turning        = res.turning;
  assign inspecting_now = res.inspecting_now;
  assign backing_up     = res.backing_up;
  assign inspect_step   = res.inspect_step;

endmodule

FILE: bench/rover_motion_checker.sv
// ----------------------------------------------------------------------------
// Rover motion sequencer checker
// Watches the configuration port and both item channels of the sequencer. It
// keeps its own copy of the registers and the motion state, works out the
// result of every accepted tick and compares each accepted result with the
// oldest one waiting.
// ----------------------------------------------------------------------------
module rover_motion_checker import rms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [TIME_BITS-1:0] now_ms,
  input  logic [8:0]           distance_cm,
  input  logic                 cmd_valid,
  input  logic [7:0]           cmd_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 left_forward,
  input  logic [7:0]           left_pwm,
  input  logic                 right_forward,
  input  logic [7:0]           right_pwm,
  input  logic                 obstacle_seen,
  input  logic                 turning,
  input  logic                 inspecting_now,
  input  logic                 backing_up,
  input  logic [1:0]           inspect_step,
  output int                   mismatches,
  output int                   outstanding
);

  typedef logic [TIME_BITS-1:0] stamp_t;

  // Register copies.
  logic [7:0]  speed_r;
  logic [8:0]  near_r;
  logic [15:0] turn_full_r;
  logic [15:0] backup_len_r;
  logic [15:0] fwd_len_r;
  logic [15:0] pause_len_r;

  // Motion state.
  int          left_v;
  int          right_v;
  logic [7:0]  last_cmd;
  bit          obstacle;
  bit          turn_on;
  stamp_t      turn_t0;
  logic [15:0] turn_len;
  bit          insp_on;
  logic [1:0]  phase;
  stamp_t      leg_t0;
  stamp_t      pause_t0;
  stamp_t      return_len;
  bit          link_up;
  stamp_t      backup_t0;

  result_t     motion_due[$];
  result_t     want;
  int          fault_total;

  function automatic stamp_t ms_since(stamp_t now, stamp_t since);
    return now - since;
  endfunction

  function automatic void command_motors(int l, int r);
    left_v  = l;
    right_v = r;
  endfunction

  function automatic logic [7:0] duty(int v);
    int m;
    m = (v < 0) ? -v : v;
    if (m > 255) m = 255;
    return m[7:0];
  endfunction

  // Starts a half turn, or ends the running one once its time is up.
  function automatic void run_turn(stamp_t now, bit positive);
    int s;
    s = int'(speed_r);
    if (!turn_on) begin
      turn_t0  = now;
      turn_len = turn_full_r >> 1;
      if (positive) command_motors(-s, s);
      else command_motors(s, -s);
      turn_on = 1'b1;
      return;
    end
    if (ms_since(now, turn_t0) >= stamp_t'(turn_len)) begin
      command_motors(0, 0);
      turn_on  = 1'b0;
      last_cmd = CMD_NONE;
    end
  endfunction

  function automatic void step_backup(stamp_t now);
    int s;
    s = int'(speed_r);
    if (link_up) begin
      link_up   = 1'b0;
      backup_t0 = now;
      command_motors(-s, -s);
      return;
    end
    if (ms_since(now, backup_t0) >= stamp_t'(backup_len_r)) begin
      command_motors(0, 0);
      link_up = 1'b1;
    end
  endfunction

  function automatic void step_inspection(stamp_t now);
    int s;
    s = int'(speed_r);
    if (!insp_on) begin
      insp_on = 1'b1;
      phase   = PH_FORWARD;
      leg_t0  = now;
      return;
    end
    case (phase)
      PH_FORWARD: begin
        if (obstacle) begin
          // The return leg only has to cover what was driven so far.
          command_motors(0, 0);
          pause_t0   = now;
          return_len = ms_since(now, leg_t0);
          phase      = PH_PAUSE;
        end else begin
          command_motors(s, s);
          if (ms_since(now, leg_t0) >= stamp_t'(fwd_len_r)) begin
            command_motors(0, 0);
            pause_t0   = now;
            return_len = stamp_t'(fwd_len_r);
            phase      = PH_PAUSE;
          end
        end
      end
      PH_PAUSE: begin
        if (ms_since(now, pause_t0) >= stamp_t'(pause_len_r)) begin
          run_turn(now, 1'b1);
          phase = PH_TURN;
        end
      end
      PH_TURN: begin
        if (!turn_on) begin
          leg_t0 = now;
          phase  = PH_REVERSE;
        end
      end
      default: begin
        command_motors(-s, -s);
        if (ms_since(now, leg_t0) >= return_len) begin
          command_motors(0, 0);
          insp_on = 1'b0;
          phase   = PH_FORWARD;
        end
      end
    endcase
  endfunction

  function automatic result_t predict_tick(stamp_t now, logic [8:0] range_in, logic cv,
                                           logic [7:0] code);
    logic [7:0] cmd;
    bit         motion;
    int         s;
    result_t    r;
    s   = int'(speed_r);
    cmd = CMD_NONE;

    if (range_in != 9'd0 && range_in < near_r) begin
      if (!obstacle) begin
        obstacle = 1'b1;
        if (last_cmd == CMD_FWD) command_motors(0, 0);
      end
    end else begin
      obstacle = 1'b0;
    end

    if (!link_up) step_backup(now);
    if (turn_on) run_turn(now, 1'b1);
    if (insp_on) step_inspection(now);

    if (cv && code != CMD_LF && code != CMD_CR) begin
      cmd      = code;
      last_cmd = code;
    end

    if (cmd != CMD_NONE) begin
      motion = cmd inside {CMD_FWD, CMD_LEFT, CMD_STOP, CMD_RIGHT, CMD_REV,
                           CMD_TURN_Q, CMD_TURN_E};
      if (motion && (turn_on || insp_on || !link_up)) begin
        turn_on = 1'b0;
        insp_on = 1'b0;
        link_up = 1'b1;
        phase   = PH_FORWARD;
        command_motors(0, 0);
      end
      case (cmd)
        CMD_FWD:     if (obstacle) command_motors(0, 0); else command_motors(s, s);
        CMD_STOP:    command_motors(0, 0);
        CMD_REV:     command_motors(-s, -s);
        CMD_RIGHT:   command_motors(s, -s);
        CMD_LEFT:    command_motors(-s, s);
        CMD_TURN_Q:  run_turn(now, 1'b0);
        CMD_TURN_E:  run_turn(now, 1'b1);
        CMD_BACKUP:  step_backup(now);
        CMD_INSPECT: step_inspection(now);
        default: ;
      endcase
    end else if (!turn_on && !insp_on && link_up) begin
      command_motors(0, 0);
    end

    r.left_forward   = (left_v >= 0);
    r.left_pwm       = duty(left_v);
    r.right_forward  = (right_v >= 0);
    r.right_pwm      = duty(right_v);
    r.obstacle_seen  = obstacle;
    r.turning        = turn_on;
    r.inspecting_now = insp_on;
    r.backing_up     = !link_up;
    r.inspect_step   = phase;
    return r;
  endfunction

  task automatic check_field(string field, logic [7:0] expected_v, logic [7:0] actual_v);
    if (actual_v !== expected_v) begin
      $error("%s: expected %0d, got %0d", field, expected_v, actual_v);
      fault_total++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      speed_r      = 8'd150;
      near_r       = 9'd10;
      turn_full_r  = 16'd2000;
      backup_len_r = 16'd2000;
      fwd_len_r    = 16'd2000;
      pause_len_r  = 16'd100;
      left_v       = 0;
      right_v      = 0;
      last_cmd     = CMD_NONE;
      obstacle     = 1'b0;
      turn_on      = 1'b0;
      turn_t0      = '0;
      turn_len     = '0;
      insp_on      = 1'b0;
      phase        = PH_FORWARD;
      leg_t0       = '0;
      pause_t0     = '0;
      return_len   = stamp_t'(2000);
      link_up      = 1'b1;
      backup_t0    = '0;
      fault_total  = 0;
      motion_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DRIVE_SPEED:  speed_r      = cfg_data[7:0];
          REG_NEAR_LIMIT:   near_r       = cfg_data[8:0];
          REG_FULL_TURN:    turn_full_r  = cfg_data;
          REG_BACKUP:       backup_len_r = cfg_data;
          REG_INSPECT_FWD:  fwd_len_r    = cfg_data;
          REG_SETTLE_PAUSE: pause_len_r  = cfg_data;
          default: ;
        endcase
      end
      // Results are checked before this edge's tick is queued: the block
      // cannot answer a tick in the cycle it takes it.
      if (out_valid && !out_stall) begin
        if (motion_due.size() == 0) begin
          $error("result item with no tick waiting for it");
          fault_total++;
        end else begin
          want = motion_due.pop_front();
          check_field("left_forward", 8'(want.left_forward), 8'(left_forward));
          check_field("left_pwm", want.left_pwm, left_pwm);
          check_field("right_forward", 8'(want.right_forward), 8'(right_forward));
          check_field("right_pwm", want.right_pwm, right_pwm);
          check_field("obstacle_seen", 8'(want.obstacle_seen), 8'(obstacle_seen));
          check_field("turning", 8'(want.turning), 8'(turning));
          check_field("inspecting_now", 8'(want.inspecting_now), 8'(inspecting_now));
          check_field("backing_up", 8'(want.backing_up), 8'(backing_up));
          check_field("inspect_step", 8'(want.inspect_step), 8'(inspect_step));
        end
      end
      if (in_valid && !in_stall)
        motion_due.push_back(predict_tick(now_ms, distance_cm, cmd_valid, cmd_byte));
    end
    mismatches  <= fault_total;
    outstanding <= motion_due.size();
  end

endmodule

FILE: bench/rover_motion_sequencer_tb.sv
// ----------------------------------------------------------------------------
// Rover motion sequencer testbench
// Drives control ticks into the sequencer: a directed run through every
// command, obstacle edges, timed actions and timestamp wrap, then random
// episodes of a kick-off command followed by mostly idle ticks under six
// register settings and three idling mixes. The checker beside the block
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module rover_motion_sequencer_tb;
  import rms_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_SEGMENT = 48;

  // Command bytes with no meaning to the block, and register indexes past
  // the end of the list.
  localparam logic [7:0] CMD_UNKNOWN_F = 8'h66;
  localparam logic [7:0] CMD_ALL_ONES  = 8'hFF;
  localparam logic [7:0] CMD_NUL       = 8'h00;
  localparam logic [2:0] REG_SPARE_LO  = 3'd6;
  localparam logic [2:0] REG_SPARE_HI  = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [2:0]           cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_BITS-1:0] now_ms = '0;
  logic [8:0]           distance_cm = '0;
  logic                 cmd_valid = 1'b0;
  logic [7:0]           cmd_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 left_forward;
  logic [7:0]           left_pwm;
  logic                 right_forward;
  logic [7:0]           right_pwm;
  logic                 obstacle_seen;
  logic                 turning;
  logic                 inspecting_now;
  logic                 backing_up;
  logic [1:0]           inspect_step;

  int                   mismatches;
  int                   outstanding;

  int                   send_idle_pct = 15;
  int                   recv_idle_pct = 57;
  int                   send_quiet = 0;
  int                   recv_quiet = 0;
  int                   stall_free_cycles = 0;
  int                   time_span = 2000;
  int                   ticks_sent;
  logic [31:0]          clock_ms = '0;

  rover_motion_sequencer dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .now_ms(now_ms), .distance_cm(distance_cm), .cmd_valid(cmd_valid), .cmd_byte(cmd_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_forward(left_forward), .left_pwm(left_pwm),
    .right_forward(right_forward), .right_pwm(right_pwm),
    .obstacle_seen(obstacle_seen), .turning(turning), .inspecting_now(inspecting_now),
    .backing_up(backing_up), .inspect_step(inspect_step)
  );

  rover_motion_checker motion_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .now_ms(now_ms), .distance_cm(distance_cm), .cmd_valid(cmd_valid), .cmd_byte(cmd_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_forward(left_forward), .left_pwm(left_pwm),
    .right_forward(right_forward), .right_pwm(right_pwm),
    .obstacle_seen(obstacle_seen), .turning(turning), .inspecting_now(inspecting_now),
    .backing_up(backing_up), .inspect_step(inspect_step),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver side: random stalls with occasional stall-free stretches.
  always @(posedge clk) begin
    if (recv_quiet > 0) recv_quiet--;
    else if ($urandom_range(0, 99) < 3) recv_quiet = $urandom_range(20, 80);
    out_stall <= (recv_quiet == 0) && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // The watchdog restarts whenever either channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stall_free_cycles <= 0;
    end else if (stall_free_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_free_cycles <= stall_free_cycles + 1;
    end
  end

  function automatic logic [7:0] motion_cmd(int k);
    case (k)
      0: return CMD_FWD;
      1: return CMD_LEFT;
      2: return CMD_STOP;
      3: return CMD_RIGHT;
      4: return CMD_REV;
      5: return CMD_TURN_Q;
      default: return CMD_TURN_E;
    endcase
  endfunction

  // Presents one tick and returns at the edge that takes it. Valid is left
  // high so that back-to-back items need no second assignment in one step.
  task automatic send_tick(logic [31:0] t, logic [8:0] range_cm, logic cv, logic [7:0] code);
    int gap;
    gap = 0;
    if (send_quiet > 0) send_quiet--;
    else if ($urandom_range(0, 99) < 4) send_quiet = $urandom_range(10, 40);
    if (send_quiet == 0)
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    now_ms      <= t;
    distance_cm <= range_cm;
    cmd_valid   <= cv;
    cmd_byte    <= code;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_tick(logic cv, logic [7:0] code);
    int          r;
    logic [8:0]  range_cm;
    r = $urandom_range(0, 99);
    if (r < 40) clock_ms += $urandom_range(0, 40);
    else if (r < 75) clock_ms += $urandom_range(0, time_span / 4);
    else if (r < 95) clock_ms += $urandom_range(0, time_span + time_span / 2);
    else clock_ms = $urandom();
    r = $urandom_range(0, 99);
    if (r < 12) range_cm = '0;
    else if (r < 35) range_cm = 9'($urandom_range(1, 20));
    else range_cm = 9'($urandom_range(0, 511));
    send_tick(clock_ms, range_cm, cv, code);
    ticks_sent++;
  endtask

  // One kick-off command, then mostly command-free ticks so that timed
  // actions run to their end.
  task automatic run_episode();
    int         p;
    int         follow;
    logic [7:0] kick;
    p = $urandom_range(0, 15);
    if (p < 7) kick = motion_cmd(p);
    else if (p < 9) kick = CMD_BACKUP;
    else if (p < 13) kick = CMD_INSPECT;
    else if (p < 14) kick = CMD_NONE;
    else kick = 8'($urandom_range(0, 255));
    random_tick(1'b1, kick);
    follow = $urandom_range(2, 14);
    repeat (follow) begin
      p = $urandom_range(0, 99);
      if (p < 45) random_tick(1'b0, 8'($urandom_range(0, 255)));
      else if (p < 60) random_tick(1'b1, CMD_NONE);
      else if (p < 65) random_tick(1'b1, (p < 63) ? CMD_CR : CMD_LF);
      else if (p < 80) random_tick(1'b1, (p < 72) ? CMD_INSPECT : CMD_BACKUP);
      else if (p < 92) random_tick(1'b1, motion_cmd($urandom_range(0, 6)));
      else random_tick(1'b1, 8'($urandom_range(0, 255)));
    end
  endtask

  // Holds the sender off until every tick has been answered.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_setting(int kind);
    logic [15:0] speed, near, full, back, fwd, pause;
    case (kind)
      0: begin
        speed = '0; near = '0; full = '0; back = '0; fwd = '0; pause = '0;
        time_span = 50;
      end
      1: begin
        speed = 16'hFFFF; near = 16'hFFFF; full = 16'hFFFF;
        back = 16'hFFFF; fwd = 16'hFFFF; pause = 16'hFFFF;
        time_span = 70000;
      end
      2: begin
        speed = 16'($urandom_range(0, 255)); near = 16'($urandom_range(0, 40));
        full = 16'($urandom_range(0, 300)); back = 16'($urandom_range(0, 300));
        fwd = 16'($urandom_range(0, 300)); pause = 16'($urandom_range(0, 300));
        time_span = 320;
      end
      3: begin
        // Upper data bits of the narrow registers are random and must be dropped.
        speed = 16'($urandom_range(0, 65535)); near = 16'($urandom_range(0, 65535));
        full = 16'($urandom_range(0, 3000)); back = 16'($urandom_range(0, 3000));
        fwd = 16'($urandom_range(0, 3000)); pause = 16'($urandom_range(0, 3000));
        time_span = 3200;
      end
      4: begin
        speed = 16'($urandom_range(0, 65535)); near = 16'($urandom_range(0, 65535));
        full = 16'($urandom_range(0, 65535)); back = 16'($urandom_range(0, 65535));
        fwd = 16'($urandom_range(0, 65535)); pause = 16'($urandom_range(0, 65535));
        time_span = 70000;
      end
      default: begin
        // Zero-length half turn, one-millisecond timers and the longest pause.
        speed = 16'd255; near = 16'd1; full = 16'd1; back = 16'd1; fwd = 16'd1;
        pause = 16'hFFFF;
        time_span = 40000;
      end
    endcase
    write_reg(REG_DRIVE_SPEED, speed);
    write_reg(REG_NEAR_LIMIT, near);
    write_reg(REG_FULL_TURN, full);
    write_reg(REG_BACKUP, back);
    write_reg(REG_INSPECT_FWD, fwd);
    write_reg(REG_SETTLE_PAUSE, pause);
    write_reg(REG_SPARE_LO, 16'($urandom_range(0, 65535)));
    write_reg(REG_SPARE_HI, 16'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset register values.
    send_tick(32'd0, 9'd0, 1'b0, CMD_FWD);
    send_tick(32'd5, 9'd511, 1'b1, CMD_FWD);
    send_tick(32'd10, 9'd5, 1'b1, CMD_CR);
    send_tick(32'd20, 9'd9, 1'b1, CMD_FWD);
    send_tick(32'd30, 9'd10, 1'b1, CMD_LF);
    send_tick(32'd40, 9'd1, 1'b1, CMD_UNKNOWN_F);
    send_tick(32'd50, 9'd100, 1'b1, CMD_LEFT);
    send_tick(32'd60, 9'd100, 1'b1, CMD_RIGHT);
    send_tick(32'd70, 9'd100, 1'b1, CMD_REV);
    send_tick(32'd75, 9'd100, 1'b1, CMD_ALL_ONES);
    send_tick(32'd80, 9'd100, 1'b1, CMD_STOP);
    send_tick(32'd90, 9'd100, 1'b1, CMD_NUL);
    send_tick(32'd100, 9'd100, 1'b1, CMD_NONE);
    // Inspection reaches its turn while a half turn is already running.
    send_tick(32'd1000, 9'd100, 1'b1, CMD_TURN_Q);
    send_tick(32'd1010, 9'd100, 1'b1, CMD_INSPECT);
    send_tick(32'd1020, 9'd5, 1'b0, CMD_NONE);
    send_tick(32'd1200, 9'd100, 1'b0, CMD_NONE);
    send_tick(32'd2100, 9'd100, 1'b0, CMD_NONE);
    send_tick(32'd2105, 9'd100, 1'b1, CMD_INSPECT);
    send_tick(32'd2200, 9'd100, 1'b0, CMD_NONE);
    send_tick(32'd2300, 9'd100, 1'b1, CMD_BACKUP);
    send_tick(32'd2400, 9'd100, 1'b1, CMD_BACKUP);
    send_tick(32'd4400, 9'd100, 1'b0, CMD_NONE);
    // A half turn whose end lies past the timestamp wrap.
    send_tick(32'hFFFF_FF00, 9'd100, 1'b1, CMD_TURN_E);
    send_tick(32'h0000_0400, 9'd100, 1'b0, CMD_NONE);
    send_tick(32'hFFFF_FFFF, 9'd100, 1'b1, CMD_INSPECT);
    send_tick(32'hFFFF_FFFF, 9'd100, 1'b1, CMD_FWD);
    drain();

    for (int seg = 0; seg < 12; seg++) begin
      if (seg == 4) begin
        send_idle_pct = 57;
        recv_idle_pct = 15;
      end
      if (seg == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setting(seg % 6);
      ticks_sent = 0;
      while (ticks_sent < ITEMS_PER_SEGMENT) run_episode();
      drain();
    end

    repeat (6) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
